/* rtl/bitvector_rank_select_engine_unit_defines.svh */
// Assertion macros shared by the checker of the rank/select engine.
// Depends on nothing; included by the checker file.
`ifndef BITVECTOR_RANK_SELECT_ENGINE_UNIT_DEFINES_SVH
`define BITVECTOR_RANK_SELECT_ENGINE_UNIT_DEFINES_SVH
`define BRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define BRS_ASSERT_RESET(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("reset check failed");
`endif

/* rtl/brse_pkg.sv */
// Types and constants of the bit vector rank/select engine.
// Depends on nothing; used by the top level, brse_ctrl and brse_datapath.
package brse_pkg;
  localparam int unsigned WordBits = 64;
  localparam int unsigned PosW = 17;

  typedef enum logic [2:0] {
    ActClear  = 3'd0,
    ActLoad   = 3'd1,
    ActRank1  = 3'd2,
    ActRank0  = 3'd3,
    ActSel1   = 3'd4,
    ActSel0   = 3'd5
  } action_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // Datapath operations driven by the controller.
  typedef enum logic [3:0] {
    OpIdle,
    OpStart,
    OpLoadRd,
    OpLoadWr,
    OpRankRd,
    OpRankFin,
    OpSelTot,
    OpSelProbe,
    OpSelStep,
    OpSelRd,
    OpSelFin,
    OpScan,
    OpSelEnd
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic scan_done;
    logic early_none;
  } stat_t;
endpackage

/* rtl/bitvector_rank_select_engine_unit.sv */
// Top level of the bit vector rank/select engine.
// Depends on brse_pkg, brse_ctrl and brse_datapath.
//
// Usage: items arrive on the in channel (action, data word, position, ordinal)
// and each produces exactly one transfer on the out channel (answer, status).
// The valid_bits register is written through the cfg channel while idle; an
// input transfer waits while a write is offered.
// One item is handled at a time; in_ready_o is high only while the engine
// waits for an item. A clear or unknown action goes straight to the final
// state, a load passes a read and a write state, a rank a read and a finish
// state. A select reads the total count, then runs a binary search over the
// word boundary counts (a probe and a step state per halving), then reads the
// chosen word and scans it one bit a cycle. The result sits in an output
// register; a stalled receiver holds the engine in its final state until the transfer completes.
// Reset clears the word count; valid_bits returns to zero. Word store
// contents are undefined until written and no clearing pass runs.
module bitvector_rank_select_engine_unit
  import brse_pkg::*;
#(
  parameter int unsigned MaxWords = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      action_i,
  input  logic [63:0]     data_word_i,
  input  logic [16:0]     bit_position_i,
  input  logic [16:0]     ordinal_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [16:0]     answer_o,
  output logic [1:0]      status_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [16:0]     cfg_data_i
);
  cmd_t cmd;
  stat_t stat;
  logic idle, done, in_fire;
  logic valid_q;
  logic [16:0] vbits_q, ans_q, ans;
  logic [1:0] st_q, st;

  assign in_ready_o = idle && !cfg_valid_i;
  assign in_fire = in_valid_i && in_ready_o;
  assign cfg_ready_o = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbits_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) vbits_q <= cfg_data_i;
      if (done) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      ans_q <= ans;
      st_q <= st;
    end
  end

  brse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .action_i, .stat_i(stat),
    .out_busy_i(valid_q && !out_ready_i), .idle_o(idle), .done_o(done), .cmd_o(cmd)
  );

  brse_datapath #(.MaxWords(MaxWords)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .action_i, .data_word_i, .bit_position_i,
    .ordinal_i, .valid_bits_i(vbits_q), .stat_o(stat), .answer_o(ans), .status_o(st)
  );

  assign out_valid_o = valid_q;
  assign answer_o = ans_q;
  assign status_o = st_q;
endmodule

/* rtl/brse_ctrl.sv */
// Controller state machine of the rank/select engine.
// Depends on brse_pkg; drives the datapath through cmd_t and reads stat_t.
module brse_ctrl
  import brse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic [2:0] action_i,
  input  stat_t   stat_i,
  input  logic    out_busy_i,
  output logic    idle_o,
  output logic    done_o,
  output cmd_t    cmd_o
);
  typedef enum logic [3:0] {
    SIdle, SLoadRd, SLoadWr, SRankRd, SRankFin, SSelTot, SSelProbe, SSelStep,
    SSelRd, SSelFin, SScan, SSelEnd, SDone
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OpIdle;
    unique case (state_q)
      SIdle: begin
        if (in_fire_i) begin
          cmd_o.op = OpStart;
          case (action_i)
            ActLoad: state_d = SLoadRd;
            ActRank1, ActRank0: state_d = SRankRd;
            ActSel1, ActSel0: state_d = SSelTot;
            default: state_d = SDone;
          endcase
        end
      end
      SLoadRd: begin cmd_o.op = OpLoadRd; state_d = SLoadWr; end
      SLoadWr: begin cmd_o.op = OpLoadWr; state_d = SDone; end
      SRankRd: begin cmd_o.op = OpRankRd; state_d = SRankFin; end
      SRankFin: begin cmd_o.op = OpRankFin; state_d = SDone; end
      SSelTot: begin
        cmd_o.op = OpSelTot;
        state_d = SSelProbe;
      end
      SSelProbe: begin
        cmd_o.op = OpSelProbe;
        if (stat_i.early_none) state_d = SDone;
        else if (stat_i.search_done) state_d = SSelRd;
        else state_d = SSelStep;
      end
      SSelStep: begin cmd_o.op = OpSelStep; state_d = SSelProbe; end
      SSelRd: begin cmd_o.op = OpSelRd; state_d = SSelFin; end
      SSelFin: begin cmd_o.op = OpSelFin; state_d = SScan; end
      SScan: begin
        cmd_o.op = OpScan;
        if (stat_i.scan_done) state_d = SSelEnd;
      end
      SSelEnd: begin cmd_o.op = OpSelEnd; state_d = SDone; end
      SDone: if (!out_busy_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == SIdle);
  assign done_o = (state_q == SDone) && !out_busy_i;
endmodule

/* rtl/brse_datapath.sv */
// Datapath of the rank/select engine: word and count memories, search and scan.
// Depends on brse_pkg; commanded by brse_ctrl.
module brse_datapath
  import brse_pkg::*;
#(
  parameter int unsigned MaxWords = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [2:0]      action_i,
  input  logic [63:0]     data_word_i,
  input  logic [PosW-1:0] bit_position_i,
  input  logic [PosW-1:0] ordinal_i,
  input  logic [PosW-1:0] valid_bits_i,
  output stat_t           stat_o,
  output logic [PosW-1:0] answer_o,
  output logic [1:0]      status_o
);
  localparam int unsigned AW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned CW = $clog2(MaxWords + 1);
  localparam int unsigned CAW = $clog2(MaxWords + 1) > 0 ? $clog2(MaxWords + 1) : 1;

  logic [63:0]     wmem [MaxWords];
  logic [PosW-1:0] cmem [MaxWords + 1];

  logic [CW-1:0]   nwords_q;
  logic [2:0]      act_q;
  logic [63:0]     data_q;
  logic [PosW-1:0] pos_q, ord_q, res_q, tot_q;
  logic [1:0]      st_q;
  logic [AW-1:0]   lo_q, hi_q;
  logic [63:0]     wrd_q;
  logic [PosW-1:0] need_q;
  logic [6:0]      bidx_q;
  logic [PosW-1:0] seen_q;
  logic [5:0]      found_q;
  logic            tot_pend_q;

  logic [63:0]     wrd_rd_q;
  logic [PosW-1:0] cnt_rd_q;
  logic [CAW-1:0]  caddr;
  logic [AW-1:0]   waddr;
  logic            want1;
  logic [PosW-1:0] clamp, lim, mid_zero, tot_now;
  logic [AW:0]     midsum;
  logic [AW-1:0]   mid;
  logic [PosW+6:0] widewords;

  assign want1 = (act_q == ActSel1);
  assign widewords = (PosW + 7)'(nwords_q) << 6;
  assign lim = (widewords > (PosW + 7)'(valid_bits_i)) ? valid_bits_i : widewords[PosW-1:0];
  assign midsum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = midsum[AW:1];

  // Memory addressing per operation.
  always_comb begin
    caddr = '0;
    waddr = '0;
    clamp = (pos_q > lim) ? lim : pos_q;
    case (cmd_i.op)
      OpLoadRd: caddr = CAW'(nwords_q);
      OpRankRd: begin
        caddr = CAW'(clamp >> 6);
        waddr = AW'(clamp >> 6);
      end
      OpSelTot: caddr = CAW'(nwords_q);
      OpSelProbe, OpSelStep: caddr = CAW'(mid) + CAW'(1);
      OpSelRd: begin
        caddr = CAW'(lo_q);
        waddr = lo_q;
      end
      default: ;
    endcase
  end

  assign mid_zero = PosW'(((PosW+7)'(mid) + 1) << 6) - cnt_rd_q;

  always_ff @(posedge clk_i) begin
    wrd_rd_q <= wmem[waddr];
    cnt_rd_q <= (caddr == '0) ? '0 : cmem[caddr];
    if (cmd_i.op == OpLoadWr && nwords_q < CW'(MaxWords)) begin
      wmem[AW'(nwords_q)] <= data_q;
      cmem[CAW'(nwords_q) + CAW'(1)] <= cnt_rd_q + PosW'($countones(data_q));
    end
  end

  // The total is still in the count read register on the first probe.
  assign tot_now = tot_pend_q ? (want1 ? cnt_rd_q : PosW'(widewords) - cnt_rd_q) : tot_q;

  logic early;
  always_comb begin
    early = (ord_q == '0) || (nwords_q == '0) || (ord_q > tot_now);
  end
  assign stat_o.early_none = early;
  assign stat_o.search_done = !(lo_q < hi_q);
  assign stat_o.scan_done = (bidx_q == 7'd64) || (seen_q == need_q);

  logic [63:0] rmask;
  assign rmask = (clamp[5:0] == 6'd0) ? 64'd0 : ((64'd1 << clamp[5:0]) - 64'd1);

  logic [PosW-1:0] rank1;
  assign rank1 = (clamp == '0) ? '0 : cnt_rd_q + PosW'($countones(wrd_rd_q & rmask));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nwords_q <= '0;
    end else if (cmd_i.op == OpStart && action_i == ActClear) begin
      nwords_q <= '0;
    end else if (cmd_i.op == OpLoadWr && nwords_q < CW'(MaxWords)) begin
      nwords_q <= nwords_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpStart: begin
        act_q <= action_i;
        data_q <= data_word_i;
        pos_q <= bit_position_i;
        ord_q <= ordinal_i;
        res_q <= '0;
        st_q <= StOk;
      end
      OpLoadWr: begin
        res_q <= PosW'(nwords_q);
        st_q <= (nwords_q < CW'(MaxWords)) ? StOk : StFull;
      end
      OpRankFin: begin
        res_q <= (act_q == ActRank0) ? pos_q - rank1 : rank1;
      end
      OpSelTot: begin
        lo_q <= '0;
        hi_q <= AW'(nwords_q - CW'(1));
      end
      OpSelProbe: begin
        if (early) st_q <= StNone;
      end
      OpSelStep: begin
        if ((want1 ? cnt_rd_q : mid_zero) < ord_q) lo_q <= mid + AW'(1);
        else hi_q <= mid;
      end
      OpSelFin: begin
        wrd_q <= want1 ? wrd_rd_q : ~wrd_rd_q;
        bidx_q <= '0;
        seen_q <= '0;
        found_q <= '0;
        need_q <= ord_q - (want1 ? cnt_rd_q : PosW'((PosW+7)'(lo_q) << 6) - cnt_rd_q);
      end
      OpScan: begin
        if (seen_q != need_q && bidx_q != 7'd64) begin
          if (wrd_q[bidx_q[5:0]]) begin
            seen_q <= seen_q + PosW'(1);
            found_q <= bidx_q[5:0];
          end
          bidx_q <= bidx_q + 7'd1;
        end
      end
      OpSelEnd: begin
        if ((PosW+7)'({lo_q, found_q}) >= (PosW+7)'(valid_bits_i)) begin
          st_q <= StNone;
          res_q <= '0;
        end else begin
          res_q <= PosW'({lo_q, found_q});
        end
      end
      default: ;
    endcase
  end

  // Total of wanted bits, captured from the count read register on the first probe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tot_pend_q <= 1'b0;
    else tot_pend_q <= (cmd_i.op == OpSelTot);
  end
  always_ff @(posedge clk_i) begin
    if (tot_pend_q) begin
      tot_q <= want1 ? cnt_rd_q : PosW'(widewords) - cnt_rd_q;
    end
  end

  assign answer_o = res_q;
  assign status_o = st_q;
endmodule

/* rtl/brse_checker.sv */
// Port-level checker of the rank/select engine, bound to the top level.
// Depends on bitvector_rank_select_engine_unit_defines.svh.
`include "bitvector_rank_select_engine_unit_defines.svh"
module brse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [16:0] answer_o,
  input logic [1:0]  status_o
);
  `BRS_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `BRS_ASSERT(a_status_legal, clk_i, rst_ni, out_valid_o |-> (status_o != 2'd3))
  `BRS_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> $stable(answer_o))
  `BRS_ASSERT_RESET(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)
endmodule

bind bitvector_rank_select_engine_unit brse_checker u_brse_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .answer_o, .status_o
);

/* dv/bitvector_rank_select_engine_unit_tb.sv */
// Self-checking testbench of the bit vector rank/select engine: a directed table, a long-vector
// pass and random phases, with every transfer checked against a table reply or a local predictor.
// Depends on brse_pkg and bitvector_rank_select_engine_unit.
`timescale 1ns / 100ps

module bitvector_rank_select_engine_unit_tb;
  import brse_pkg::*;

  localparam int unsigned NumWords = 1024;
  localparam int unsigned LongWords = 128;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned SettleCycles = 120;
  localparam logic [2:0] ActBad6 = 3'd6;
  localparam logic [2:0] ActBad7 = 3'd7;

  typedef struct {
    logic [2:0]  act;
    logic [63:0] data;
    logic [16:0] pos;
    logic [16:0] ord;
  } query_t;

  typedef struct packed {
    logic [16:0] answer;
    logic [1:0]  status;
  } reply_t;

  typedef struct {
    logic        is_cfg;
    query_t      q;
    logic        typed;
    reply_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [63:0] data_word_i = '0;
  logic [16:0] bit_position_i = '0;
  logic [16:0] ordinal_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [16:0] answer_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;

  logic [63:0] words_q [NumWords];
  int unsigned ones_upto [NumWords + 1];
  int unsigned loaded_cnt;
  int unsigned valid_len;

  reply_t      pending_q [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned quiet_cycles = 0;

  bitvector_rank_select_engine_unit #(.MaxWords(NumWords)) i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned rank_of_ones(int unsigned pos);
    int unsigned lim;
    int unsigned blk;
    int unsigned bitn;
    int unsigned r;
    lim = loaded_cnt * WordBits;
    if (valid_len < lim) lim = valid_len;
    if (pos > lim) pos = lim;
    if (pos == 0) return 0;
    blk = pos / WordBits;
    bitn = pos % WordBits;
    r = ones_upto[blk];
    if (bitn > 0) r += $countones(words_q[blk] & ((64'd1 << bitn) - 64'd1));
    return r;
  endfunction

  function automatic reply_t select_nth(int unsigned j, logic want_one);
    int unsigned total;
    int unsigned idx;
    int unsigned upto;
    int unsigned seen;
    int unsigned p;
    logic [63:0] w;
    reply_t res;
    res = '{answer: '0, status: StNone};
    if (j == 0 || loaded_cnt == 0) return res;
    total = want_one ? ones_upto[loaded_cnt] : loaded_cnt * WordBits - ones_upto[loaded_cnt];
    if (j > total) return res;
    idx = 0;
    forever begin
      upto = want_one ? ones_upto[idx + 1] : (idx + 1) * WordBits - ones_upto[idx + 1];
      if (upto >= j) break;
      idx++;
    end
    seen = want_one ? ones_upto[idx] : idx * WordBits - ones_upto[idx];
    w = want_one ? words_q[idx] : ~words_q[idx];
    p = 0;
    for (int b = 0; b < WordBits; b++) begin
      if (w[b]) begin
        seen++;
        if (seen == j) begin
          p = idx * WordBits + b;
          break;
        end
      end
    end
    if (p >= valid_len) return res;
    res.answer = p[16:0];
    res.status = StOk;
    return res;
  endfunction

  function automatic reply_t predict_reply(query_t q);
    reply_t res;
    int unsigned r;
    res = '{answer: '0, status: StOk};
    case (q.act)
      ActClear: loaded_cnt = 0;
      ActLoad: begin
        res.answer = loaded_cnt[16:0];
        if (loaded_cnt >= NumWords) begin
          res.status = StFull;
        end else begin
          words_q[loaded_cnt] = q.data;
          ones_upto[loaded_cnt + 1] = ones_upto[loaded_cnt] + $countones(q.data);
          loaded_cnt++;
        end
      end
      ActRank1: begin
        r = rank_of_ones(q.pos);
        res.answer = r[16:0];
      end
      ActRank0: begin
        r = q.pos - rank_of_ones(q.pos);
        res.answer = r[16:0];
      end
      ActSel1: res = select_nth(q.ord, 1'b1);
      ActSel0: res = select_nth(q.ord, 1'b0);
      default: ;
    endcase
    return res;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_valid_bits(logic [16:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    valid_len = value;
  endtask

  task automatic offer(query_t q, logic typed = 1'b0, reply_t want = '0);
    reply_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= q.act;
    data_word_i    <= q.data;
    bit_position_i <= q.pos;
    ordinal_i      <= q.ord;
    do @(posedge clk_i); while (!in_ready_o);
    res = predict_reply(q);
    pending_q.insert(pending_q.size(), typed ? want : res);
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(3))
      0: w = w & {$urandom, $urandom};
      1: w = w | {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int unsigned span;
    int unsigned pick;
    q.act  = ActRank1;
    q.data = rand_word();
    span = loaded_cnt * WordBits;
    q.pos = ($urandom_range(9) == 0) ? 17'($urandom_range(0, 65536))
                                     : 17'($urandom_range(0, span + 8));
    q.ord = ($urandom_range(9) == 0) ? 17'($urandom_range(0, 65536))
                                     : 17'($urandom_range(0, span / 2 + 40));
    pick = $urandom_range(99);
    if (pick < 12) q.act = ActLoad;
    else if (pick < 30) q.act = ActRank1;
    else if (pick < 45) q.act = ActRank0;
    else if (pick < 70) q.act = ActSel1;
    else if (pick < 95) q.act = ActSel0;
    else if (pick < 97) q.act = ActClear;
    else q.act = pick[0] ? ActBad6 : ActBad7;
    return q;
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off != 0) begin
        out_ready_i <= 1'b0;
        hold_off--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: answer %0d status %0d",
                                       answer_o, status_o);
      end else begin
        want = pending_q.pop_front();
        if (answer_o !== want.answer || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected answer %0d status %0d, got answer %0d status %0d",
                     want.answer, want.status, answer_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t   rows [$];
    query_t q;
    int unsigned n;
    logic [16:0] vb;

    rst_ni <= 1'b0;
    loaded_cnt = 0;
    valid_len  = 0;
    ones_upto[0] = 0;

    rows = '{
      '{1'b0, '{ActRank1, 64'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActSel1, 64'd0, 17'd0, 17'd1}, 1'b1, '{17'd0, StNone}},
      '{1'b0, '{ActClear, 64'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActBad6, 64'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActBad7, '1, '1, '1}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActLoad, '1, 17'd0, 17'd0}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActLoad, 64'd0, 17'd0, 17'd0}, 1'b1, '{17'd1, StOk}},
      '{1'b0, '{ActLoad, 64'hAAAA_AAAA_AAAA_AAAA, 17'd0, 17'd0}, 1'b1, '{17'd2, StOk}},
      '{1'b0, '{ActRank1, 64'd0, 17'd65536, 17'd0}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActRank0, 64'd0, 17'd65536, 17'd0}, 1'b1, '{17'd65536, StOk}},
      '{1'b0, '{ActSel0, 64'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, StNone}},
      '{1'b1, '{ActClear, 64'd0, 17'd65536, 17'd0}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActRank1, 64'd0, 17'd64, 17'd0}, 1'b1, '{17'd64, StOk}},
      '{1'b0, '{ActRank1, 64'd0, 17'd65536, 17'd0}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActRank0, 64'd0, 17'd150, 17'd0}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActSel1, 64'd0, 17'd0, 17'd1}, 1'b1, '{17'd0, StOk}},
      '{1'b0, '{ActSel0, 64'd0, 17'd0, 17'd1}, 1'b1, '{17'd64, StOk}},
      '{1'b0, '{ActSel1, 64'd0, 17'd0, 17'd96}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActSel1, 64'd0, 17'd0, 17'd97}, 1'b1, '{17'd0, StNone}},
      '{1'b0, '{ActSel0, 64'd0, 17'd0, 17'd96}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActSel0, 64'd0, 17'd0, 17'd65536}, 1'b1, '{17'd0, StNone}},
      '{1'b1, '{ActClear, 64'd0, 17'd100, 17'd0}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActSel0, 64'd0, 17'd0, 17'd40}, 1'b0, '{17'd0, StOk}},
      '{1'b0, '{ActRank1, 64'd0, 17'd200, 17'd0}, 1'b0, '{17'd0, StOk}}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 10;
    recv_stall_pct = 47;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        in_valid_i <= 1'b0;
        write_valid_bits(rows[i].q.pos);
      end else begin
        offer(rows[i].q, rows[i].typed, rows[i].want);
      end
    end

    // Build a long vector, then probe it with rank, select and unknown queries.
    in_valid_i <= 1'b0;
    write_valid_bits(17'd65536);
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    q = '{ActClear, 64'd0, 17'd0, 17'd0};
    offer(q);
    for (int k = 0; k < LongWords; k++) begin
      q = '{ActLoad, rand_word(), 17'd0, 17'd0};
      offer(q);
    end
    for (int k = 0; k < 24; k++) begin
      q = rand_query();
      if (q.act == ActClear || q.act == ActLoad) q.act = ActSel1;
      offer(q);
    end
    in_valid_i <= 1'b0;
    write_valid_bits(17'($urandom_range(1, 65535)));
    for (int k = 0; k < 12; k++) begin
      q = rand_query();
      q.act = k[0] ? ActSel0 : ActRank0;
      offer(q);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 47 : 0;
      recv_stall_pct = (ph == 0) ? 47 : (ph == 1) ? 10 : 0;
      for (int s = 0; s < 4; s++) begin
        in_valid_i <= 1'b0;
        n = $urandom_range(0, 3);
        vb = (n == 0) ? 17'd0 : (n == 1) ? 17'd65536 : 17'($urandom_range(0, 1600));
        write_valid_bits(vb);
        q = '{ActClear, 64'd0, 17'd0, 17'd0};
        offer(q);
        n = $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
          q = '{ActLoad, rand_word(), 17'd0, 17'd0};
          offer(q);
        end
        if (ph == 1 && s == 1) hold_off = 400;
        for (int k = 0; k < 20; k++) begin
          if (ph == 2 && s == 2 && k == 10) begin
            in_valid_i <= 1'b0;
            wait_drained();
          end
          offer(rand_query());
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
